@@ src/mhtq_pkg.sv @@
// Shared types, constants and helpers for the min-heap timer queue.
`default_nettype none
package mhtq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int MAX_ID_DEF   = 255;

    localparam int ID_W     = 8;
    localparam int NUM_IDS  = 256;
    localparam int DLY_W    = 24;
    localparam int TIME_W   = 32;
    localparam int ND_W     = 25;
    localparam int ST_W     = 2;
    localparam int OP_W     = 2;
    localparam int MAXID_W  = 16;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_FIRE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_SET_STATUS,
        DP_ADD_OLD,
        DP_ADD_NEW,
        DP_CLEAR,
        DP_TICK,
        DP_RM_START,
        DP_LOAD_CUR,
        DP_DN_RD1,
        DP_DN_RD2,
        DP_DN_SEL,
        DP_MOVE_BEST,
        DP_UP_RD,
        DP_MOVE_PAR,
        DP_WR_FIN,
        DP_RD_TOP,
        DP_ND,
        DP_OUT_RD,
        DP_OUT_LD
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t code;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic add_bad;
        logic fire_bad;
        logic present;
        logic full;
        logic cnt_zero;
        logic rm_need;
        logic has_child;
        logic cur_lt_best;
        logic moved;
        logic hole_zero;
        logic par_lt_cur;
        logic top_expired;
        logic out_free;
        logic out_last;
    } stat_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] expiry;
    } entry_t;

    // wrap-safe ordering: compare distances from now
    function automatic logic key_lt(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b,
                                    input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] ka;
        logic [TIME_W-1:0] kb;
        ka = a - now;
        kb = b - now;
        return ka < kb;
    endfunction

endpackage
`default_nettype wire

@@ src/min_heap_timer_queue_core.sv @@
// Top level of the min-heap timer queue: controller plus datapath.
// One item at a time. With no sift an item passes S_DECODE, S_ND_RD, S_ND_CALC, S_OUT_RD
// and S_OUT_LD, each further result S_OUT_RD and S_OUT_LD. A heap level takes S_DN_RD1,
// S_DN_RD2, S_DN_SEL and S_DN_CMP down and S_UP_RD and S_UP_CMP up, set by the single heap
// read port. A removal adds S_RM_LD before its sift; a tick, one removal per timer fired.
// Reset: synchronous active-low aresetn empties the queue and zeroes the clock.
`default_nettype none
module min_heap_timer_queue_core #(
    parameter int CAPACITY = mhtq_pkg::CAPACITY_DEF,
    parameter int MAX_ID   = mhtq_pkg::MAX_ID_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [mhtq_pkg::S_DATA_W-1:0]   s_tdata,  // entry_id[7:0], delay_ms[31:8]
    input  wire logic [mhtq_pkg::OP_W-1:0]       s_tuser,  // op[1:0]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [mhtq_pkg::M_DATA_W-1:0]        m_tdata,  // fired_id[7:0], status[9:8],
                                                           // next_delay[34:10]
    output logic                                 m_tuser,  // fired[0]
    output logic                                 m_tlast
);

    mhtq_pkg::cmd_t  cmd;
    mhtq_pkg::stat_t stat;

    mhtq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mhtq_dp #(
        .CAPACITY (CAPACITY),
        .MAX_ID   (MAX_ID)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

@@ src/mhtq_ctrl.sv @@
// Controller state machine for the min-heap timer queue.
`default_nettype none
module mhtq_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  mhtq_pkg::stat_t     stat,
    output mhtq_pkg::cmd_t      cmd
);

    typedef enum logic [16:0] {
        S_IDLE    = 17'b00000000000000001,
        S_DECODE  = 17'b00000000000000010,
        S_RM_LD   = 17'b00000000000000100,
        S_DN_RD1  = 17'b00000000000001000,
        S_DN_RD2  = 17'b00000000000010000,
        S_DN_SEL  = 17'b00000000000100000,
        S_DN_CMP  = 17'b00000000001000000,
        S_UP_RD   = 17'b00000000010000000,
        S_UP_CMP  = 17'b00000000100000000,
        S_WR_FIN  = 17'b00000001000000000,
        S_TK_RD   = 17'b00000010000000000,
        S_TK_CHK  = 17'b00000100000000000,
        S_ND_RD   = 17'b00001000000000000,
        S_ND_CALC = 17'b00010000000000000,
        S_OUT_RD  = 17'b00100000000000000,
        S_OUT_LD  = 17'b01000000000000000,
        S_SPARE   = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = mhtq_pkg::DP_NOP;
        cmd.code   = mhtq_pkg::ST_OK;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = mhtq_pkg::DP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (stat.op)
                    mhtq_pkg::OP_ADD: begin
                        if (stat.add_bad) begin
                            cmd.op     = mhtq_pkg::DP_SET_STATUS;
                            cmd.code   = mhtq_pkg::ST_INVALID;
                            state_next = S_ND_RD;
                        end else if (stat.present) begin
                            cmd.op     = mhtq_pkg::DP_ADD_OLD;
                            state_next = S_DN_RD1;
                        end else if (stat.full) begin
                            cmd.op     = mhtq_pkg::DP_SET_STATUS;
                            cmd.code   = mhtq_pkg::ST_FULL;
                            state_next = S_ND_RD;
                        end else begin
                            cmd.op     = mhtq_pkg::DP_ADD_NEW;
                            state_next = S_UP_RD;
                        end
                    end
                    mhtq_pkg::OP_FIRE: begin
                        if (stat.fire_bad) begin
                            cmd.op     = mhtq_pkg::DP_SET_STATUS;
                            cmd.code   = mhtq_pkg::ST_INVALID;
                            state_next = S_ND_RD;
                        end else if (!stat.present) begin
                            cmd.op     = mhtq_pkg::DP_SET_STATUS;
                            cmd.code   = mhtq_pkg::ST_UNKNOWN;
                            state_next = S_ND_RD;
                        end else begin
                            cmd.op     = mhtq_pkg::DP_RM_START;
                            state_next = stat.rm_need ? S_RM_LD : S_ND_RD;
                        end
                    end
                    mhtq_pkg::OP_TICK: begin
                        cmd.op     = mhtq_pkg::DP_TICK;
                        state_next = S_TK_RD;
                    end
                    mhtq_pkg::OP_CLEAR: begin
                        cmd.op     = mhtq_pkg::DP_CLEAR;
                        state_next = S_ND_RD;
                    end
                    default: state_next = S_ND_RD;
                endcase
            end
            S_RM_LD: begin
                cmd.op     = mhtq_pkg::DP_LOAD_CUR;
                state_next = S_DN_RD1;
            end
            S_DN_RD1: begin
                if (stat.has_child) begin
                    cmd.op     = mhtq_pkg::DP_DN_RD1;
                    state_next = S_DN_RD2;
                end else begin
                    state_next = stat.moved ? S_WR_FIN : S_UP_RD;
                end
            end
            S_DN_RD2: begin
                cmd.op     = mhtq_pkg::DP_DN_RD2;
                state_next = S_DN_SEL;
            end
            S_DN_SEL: begin
                cmd.op     = mhtq_pkg::DP_DN_SEL;
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (stat.cur_lt_best) begin
                    state_next = stat.moved ? S_WR_FIN : S_UP_RD;
                end else begin
                    cmd.op     = mhtq_pkg::DP_MOVE_BEST;
                    state_next = S_DN_RD1;
                end
            end
            S_UP_RD: begin
                if (stat.hole_zero) begin
                    state_next = S_WR_FIN;
                end else begin
                    cmd.op     = mhtq_pkg::DP_UP_RD;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (stat.par_lt_cur) begin
                    state_next = S_WR_FIN;
                end else begin
                    cmd.op     = mhtq_pkg::DP_MOVE_PAR;
                    state_next = S_UP_RD;
                end
            end
            S_WR_FIN: begin
                cmd.op     = mhtq_pkg::DP_WR_FIN;
                state_next = (stat.op == mhtq_pkg::OP_TICK) ? S_TK_RD : S_ND_RD;
            end
            S_TK_RD: begin
                if (stat.cnt_zero) begin
                    state_next = S_ND_RD;
                end else begin
                    cmd.op     = mhtq_pkg::DP_RD_TOP;
                    state_next = S_TK_CHK;
                end
            end
            S_TK_CHK: begin
                if (stat.top_expired) begin
                    cmd.op     = mhtq_pkg::DP_RM_START;
                    state_next = stat.rm_need ? S_RM_LD : S_TK_RD;
                end else begin
                    state_next = S_ND_RD;
                end
            end
            S_ND_RD: begin
                cmd.op     = mhtq_pkg::DP_RD_TOP;
                state_next = S_ND_CALC;
            end
            S_ND_CALC: begin
                cmd.op     = mhtq_pkg::DP_ND;
                state_next = S_OUT_RD;
            end
            S_OUT_RD: begin
                cmd.op     = mhtq_pkg::DP_OUT_RD;
                state_next = S_OUT_LD;
            end
            S_OUT_LD: begin
                if (stat.out_free) begin
                    cmd.op     = mhtq_pkg::DP_OUT_LD;
                    state_next = stat.out_last ? S_IDLE : S_OUT_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ src/mhtq_dp.sv @@
// Datapath: heap and slot memories, presence bits, clock, sift registers, result register.
`default_nettype none
module mhtq_dp #(
    parameter int CAPACITY = mhtq_pkg::CAPACITY_DEF,
    parameter int MAX_ID   = mhtq_pkg::MAX_ID_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  mhtq_pkg::cmd_t                       cmd,
    output mhtq_pkg::stat_t                      stat,
    input  wire logic [mhtq_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic [mhtq_pkg::OP_W-1:0]       s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [mhtq_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                 m_tuser,
    output logic                                 m_tlast
);

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CHW    = SLOT_W + 2;
    localparam int ID_W   = mhtq_pkg::ID_W;
    localparam int TW     = mhtq_pkg::TIME_W;

    mhtq_pkg::entry_t heap_mem [CAPACITY];
    logic [SLOT_W-1:0] slot_mem [mhtq_pkg::NUM_IDS];
    logic [ID_W-1:0]   fbuf_mem [CAPACITY];

    logic [mhtq_pkg::NUM_IDS-1:0] present_reg;
    logic [CNT_W-1:0]  count_reg, nfired_reg, oidx_reg, limit_reg;
    logic [TW-1:0]     now_reg;
    mhtq_pkg::op_t     op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [mhtq_pkg::DLY_W-1:0] dly_reg;
    mhtq_pkg::status_t status_reg;
    logic [mhtq_pkg::ND_W-1:0]  nd_reg;
    mhtq_pkg::entry_t  cur_reg, best_reg, hrd_reg;
    logic [SLOT_W-1:0] hole_reg, start_reg, best_slot_reg, slot_rd_reg;
    logic [ID_W-1:0]   fbuf_rd_reg;
    logic              mvalid_reg;
    logic [mhtq_pkg::M_DATA_W-1:0] mdata_reg;
    logic              muser_reg, mlast_reg;

    logic [CHW-1:0]    child0, child1;
    logic [SLOT_W-1:0] parent, rm_slot, hrd_addr;
    logic [CNT_W-1:0]  cnt_m1;
    logic [ID_W-1:0]   rm_id;
    logic [TW-1:0]     top_key, new_exp;
    logic              hrd_en, id_ok;
    logic [CNT_W-1:0]  oidx_p1;

    assign child0  = CHW'({hole_reg, 1'b1});
    assign child1  = child0 + CHW'(1);
    assign parent  = SLOT_W'((hole_reg - SLOT_W'(1)) >> 1);
    assign cnt_m1  = count_reg - CNT_W'(1);
    assign rm_slot = (op_reg == mhtq_pkg::OP_TICK) ? '0 : slot_rd_reg;
    assign rm_id   = (op_reg == mhtq_pkg::OP_TICK) ? hrd_reg.id : id_reg;
    assign top_key = hrd_reg.expiry - now_reg;
    assign new_exp = now_reg + TW'(dly_reg);
    assign id_ok   = (id_reg != '0) &&
                     ({{(mhtq_pkg::MAXID_W-ID_W){1'b0}}, id_reg} <= mhtq_pkg::MAXID_W'(MAX_ID));
    assign oidx_p1 = oidx_reg + CNT_W'(1);

    always_comb begin
        stat.op          = op_reg;
        stat.add_bad     = !id_ok || (dly_reg == '0);
        stat.fire_bad    = !id_ok;
        stat.present     = present_reg[id_reg];
        stat.full        = (count_reg >= CNT_W'(CAPACITY));
        stat.cnt_zero    = (count_reg == '0);
        stat.rm_need     = (CNT_W'(rm_slot) < cnt_m1);
        stat.has_child   = (child0 < CHW'(limit_reg));
        stat.cur_lt_best = mhtq_pkg::key_lt(cur_reg.expiry, best_reg.expiry, now_reg);
        stat.moved       = (hole_reg != start_reg);
        stat.hole_zero   = (hole_reg == '0);
        stat.par_lt_cur  = mhtq_pkg::key_lt(hrd_reg.expiry, cur_reg.expiry, now_reg);
        stat.top_expired = (top_key == '0) || top_key[TW-1];
        stat.out_free    = !mvalid_reg || m_tready;
        stat.out_last    = (nfired_reg == '0) || (oidx_p1 >= nfired_reg);
    end

    // heap read address
    always_comb begin
        hrd_en   = 1'b1;
        hrd_addr = '0;
        unique case (cmd.op)
            mhtq_pkg::DP_RM_START: hrd_addr = cnt_m1[SLOT_W-1:0];
            mhtq_pkg::DP_DN_RD1:   hrd_addr = child0[SLOT_W-1:0];
            mhtq_pkg::DP_DN_RD2:   hrd_addr = child1[SLOT_W-1:0];
            mhtq_pkg::DP_UP_RD:    hrd_addr = parent;
            mhtq_pkg::DP_RD_TOP:   hrd_addr = '0;
            default:               hrd_en   = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (hrd_en) begin
            hrd_reg <= heap_mem[hrd_addr];
        end
        unique case (cmd.op)
            mhtq_pkg::DP_MOVE_BEST: heap_mem[hole_reg] <= best_reg;
            mhtq_pkg::DP_MOVE_PAR:  heap_mem[hole_reg] <= hrd_reg;
            mhtq_pkg::DP_WR_FIN:    heap_mem[hole_reg] <= cur_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == mhtq_pkg::DP_LOAD) begin
            slot_rd_reg <= slot_mem[s_tdata[ID_W-1:0]];
        end
        unique case (cmd.op)
            mhtq_pkg::DP_MOVE_BEST: slot_mem[best_reg.id] <= hole_reg;
            mhtq_pkg::DP_MOVE_PAR:  slot_mem[hrd_reg.id]  <= hole_reg;
            mhtq_pkg::DP_WR_FIN:    slot_mem[cur_reg.id]  <= hole_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == mhtq_pkg::DP_OUT_RD) begin
            fbuf_rd_reg <= fbuf_mem[oidx_reg[SLOT_W-1:0]];
        end
        if (cmd.op == mhtq_pkg::DP_RM_START) begin
            fbuf_mem[nfired_reg[SLOT_W-1:0]] <= rm_id;
        end
    end

    // payload and sift registers
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            mhtq_pkg::DP_LOAD: begin
                op_reg     <= mhtq_pkg::op_t'(s_tuser);
                id_reg     <= s_tdata[ID_W-1:0];
                dly_reg    <= s_tdata[ID_W +: mhtq_pkg::DLY_W];
                status_reg <= mhtq_pkg::ST_OK;
            end
            mhtq_pkg::DP_SET_STATUS: status_reg <= cmd.code;
            mhtq_pkg::DP_ADD_OLD: begin
                cur_reg   <= '{id: id_reg, expiry: new_exp};
                hole_reg  <= slot_rd_reg;
                start_reg <= slot_rd_reg;
                limit_reg <= count_reg;
            end
            mhtq_pkg::DP_ADD_NEW: begin
                cur_reg   <= '{id: id_reg, expiry: new_exp};
                hole_reg  <= count_reg[SLOT_W-1:0];
                start_reg <= count_reg[SLOT_W-1:0];
            end
            mhtq_pkg::DP_RM_START: begin
                hole_reg  <= rm_slot;
                start_reg <= rm_slot;
                limit_reg <= cnt_m1;
            end
            mhtq_pkg::DP_LOAD_CUR: cur_reg <= hrd_reg;
            mhtq_pkg::DP_DN_RD2: begin
                best_reg      <= hrd_reg;
                best_slot_reg <= child0[SLOT_W-1:0];
            end
            mhtq_pkg::DP_DN_SEL: begin
                if ((child1 < CHW'(limit_reg)) &&
                    mhtq_pkg::key_lt(hrd_reg.expiry, best_reg.expiry, now_reg)) begin
                    best_reg      <= hrd_reg;
                    best_slot_reg <= child1[SLOT_W-1:0];
                end
            end
            mhtq_pkg::DP_MOVE_BEST: hole_reg <= best_slot_reg;
            mhtq_pkg::DP_MOVE_PAR:  hole_reg <= parent;
            mhtq_pkg::DP_ND: begin
                if (count_reg == '0) begin
                    nd_reg <= '1;
                end else if (top_key[TW-1]) begin
                    nd_reg <= '0;
                end else if (top_key[TW-2:mhtq_pkg::DLY_W] != '0) begin
                    nd_reg <= {1'b0, {mhtq_pkg::DLY_W{1'b1}}};
                end else begin
                    nd_reg <= {1'b0, top_key[mhtq_pkg::DLY_W-1:0]};
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            now_reg     <= '0;
            present_reg <= '0;
            nfired_reg  <= '0;
            oidx_reg    <= '0;
            mvalid_reg  <= 1'b0;
        end else begin
            unique case (cmd.op)
                mhtq_pkg::DP_LOAD: nfired_reg <= '0;
                mhtq_pkg::DP_ADD_NEW: begin
                    count_reg           <= count_reg + CNT_W'(1);
                    present_reg[id_reg] <= 1'b1;
                end
                mhtq_pkg::DP_CLEAR: begin
                    count_reg   <= '0;
                    present_reg <= '0;
                end
                mhtq_pkg::DP_TICK: now_reg <= now_reg + TW'(1);
                mhtq_pkg::DP_RM_START: begin
                    count_reg          <= cnt_m1;
                    present_reg[rm_id] <= 1'b0;
                    nfired_reg         <= nfired_reg + CNT_W'(1);
                end
                mhtq_pkg::DP_ND:     oidx_reg <= '0;
                mhtq_pkg::DP_OUT_LD: oidx_reg <= oidx_p1;
                default: ;
            endcase
            if (cmd.op == mhtq_pkg::DP_OUT_LD) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == mhtq_pkg::DP_OUT_LD) begin
            muser_reg <= (nfired_reg != '0);
            mlast_reg <= stat.out_last;
            mdata_reg <= {{(mhtq_pkg::M_DATA_W - mhtq_pkg::ND_W - mhtq_pkg::ST_W - ID_W){1'b0}},
                          nd_reg, status_reg,
                          (nfired_reg != '0) ? fbuf_rd_reg : {ID_W{1'b0}}};
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;
    assign m_tlast  = mlast_reg;

endmodule
`default_nettype wire
